/* design/assert_macros.svh */
// assertion macros used by the pushout design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define CSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/csp_pkg.sv */
// package: widths, stage counts and codes of the circle segment pushout
package csp_pkg;

  localparam int COORD_W   = 16;
  localparam int RAD_W     = 12;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int T_W       = 16;
  localparam int LEN_W     = 2 * DIFF_W - 1;
  localparam int Q_W       = 20;
  localparam int ROOT_W    = 20;
  localparam int RAD2_W    = 2 * ROOT_W;
  localparam int MAG_W     = RAD_W;
  localparam int OV_W      = RAD_W + 8;
  localparam int MQ_W      = 25;
  localparam int NUM_W     = MAG_W + OV_W + 2;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int MREM_W    = DEN_W + 1;
  localparam int NSTG      = 72;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(240);

  typedef enum logic [1:0] {
    MODE_A   = 2'd0,
    MODE_B   = 2'd1,
    MODE_MID = 2'd2
  } mode_t;

endpackage

/* design/circle_segment_pushout.sv */
// top level: pipelined circle versus wall segment pushout
//
// input channel in_*: one transaction carries a circle center and the two
// endpoints of one wall, signed Q12.4. result channel out_*: the resolved
// center, saturated to Q12.4, and a pushed flag. cfg_we/cfg_data write the
// 12-bit radius (reset value 15.0); write it only while the pipe is empty.
//
// one transaction can enter every cycle while in_stall is low. the depth is
// set by three bit-per-stage units: a 16-stage divider for the projection
// parameter, a 20-stage square root for the distance and a 25-stage divider
// for the pushout scale.
//
// the pipe moves as one: it advances whenever the output register is empty
// or its transaction is taken. when out_stall holds a valid result, every
// stage holds and in_stall rises in the same cycle, so nothing is lost or
// repeated. bubbles travel as cleared valid bits.
//
// synchronous active-low reset clears all valid bits and reloads the radius.
`include "assert_macros.svh"

module circle_segment_pushout import csp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic signed [COORD_W-1:0] in_wall_ax,
  input  logic signed [COORD_W-1:0] in_wall_ay,
  input  logic signed [COORD_W-1:0] in_wall_bx,
  input  logic signed [COORD_W-1:0] in_wall_by,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_new_x,
  output logic signed [COORD_W-1:0] out_new_y,
  output logic                      out_pushed,
  input  logic                      cfg_we,
  input  logic [RAD_W-1:0]          cfg_data
);

  // stage counts of the iterative units
  localparam int TD_N = T_W;
  localparam int SQ_N = ROOT_W;
  localparam int MD_N = MQ_W;

  logic advance;
  logic [NSTG-1:0] vld_r;

  // radius and its square, kept side by side
  logic [RAD_W-1:0]   radius_r;
  logic [2*RAD_W-1:0] rsq_r;

  assign advance   = !vld_r[NSTG-1] || !out_stall;
  assign in_stall  = !advance;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      radius_r <= RADIUS_RST;
      rsq_r    <= (2*RAD_W)'(RADIUS_RST) * (2*RAD_W)'(RADIUS_RST);
    end else begin
      if (advance) begin
        vld_r <= {vld_r[NSTG-2:0], in_valid};
      end
      if (cfg_we) begin
        radius_r <= cfg_data;
        rsq_r    <= (2*RAD_W)'(cfg_data) * (2*RAD_W)'(cfg_data);
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 1: differences against both endpoints
  logic signed [COORD_W-1:0] s1_cx_r, s1_cy_r;
  logic signed [DIFF_W-1:0]  s1_dx_r, s1_dy_r, s1_px_r, s1_py_r, s1_ex_r, s1_ey_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cx_r <= in_center_x;
      s1_cy_r <= in_center_y;
      s1_dx_r <= DIFF_W'(in_wall_bx) - DIFF_W'(in_wall_ax);
      s1_dy_r <= DIFF_W'(in_wall_by) - DIFF_W'(in_wall_ay);
      s1_px_r <= DIFF_W'(in_center_x) - DIFF_W'(in_wall_ax);
      s1_py_r <= DIFF_W'(in_center_y) - DIFF_W'(in_wall_ay);
      s1_ex_r <= DIFF_W'(in_center_x) - DIFF_W'(in_wall_bx);
      s1_ey_r <= DIFF_W'(in_center_y) - DIFF_W'(in_wall_by);
    end
  end

  // stage 2: squares and dot terms
  logic signed [2*DIFF_W-1:0] s2_dxx_r, s2_dyy_r, s2_pdx_r, s2_pdy_r;
  logic signed [COORD_W-1:0]  s2_cx_r, s2_cy_r;
  logic signed [DIFF_W-1:0]   s2_dx_r, s2_dy_r, s2_px_r, s2_py_r, s2_ex_r, s2_ey_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_dxx_r <= s1_dx_r * s1_dx_r;
      s2_dyy_r <= s1_dy_r * s1_dy_r;
      s2_pdx_r <= s1_px_r * s1_dx_r;
      s2_pdy_r <= s1_py_r * s1_dy_r;
      s2_cx_r  <= s1_cx_r;
      s2_cy_r  <= s1_cy_r;
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_px_r  <= s1_px_r;
      s2_py_r  <= s1_py_r;
      s2_ex_r  <= s1_ex_r;
      s2_ey_r  <= s1_ey_r;
    end
  end

  // stage 3: length squared, dot product, clamp decision
  logic signed [2*DIFF_W:0] s3_lensq, s3_dot;
  mode_t                    s3_mode;

  always_comb begin
    s3_lensq = (2*DIFF_W+1)'(s2_dxx_r) + (2*DIFF_W+1)'(s2_dyy_r);
    s3_dot   = (2*DIFF_W+1)'(s2_pdx_r) + (2*DIFF_W+1)'(s2_pdy_r);
    // negative or zero dot product: projection falls at or before the first endpoint
    if (s3_lensq == '0 || s3_dot[2*DIFF_W] || s3_dot == '0) begin
      s3_mode = MODE_A;
    end else if (s3_dot >= s3_lensq) begin
      s3_mode = MODE_B;
    end else begin
      s3_mode = MODE_MID;
    end
  end

  // projection divider, one quotient bit per stage; index 0 is stage 3
  logic [LEN_W:0]            td_rem_r [TD_N+1];
  logic [LEN_W-1:0]          td_den_r [TD_N+1];
  logic [T_W-1:0]            td_q_r   [TD_N+1];
  mode_t                     td_mode_r[TD_N+1];
  logic signed [COORD_W-1:0] td_cx_r  [TD_N+1];
  logic signed [COORD_W-1:0] td_cy_r  [TD_N+1];
  logic signed [DIFF_W-1:0]  td_dx_r  [TD_N+1];
  logic signed [DIFF_W-1:0]  td_dy_r  [TD_N+1];
  logic signed [DIFF_W-1:0]  td_px_r  [TD_N+1];
  logic signed [DIFF_W-1:0]  td_py_r  [TD_N+1];
  logic signed [DIFF_W-1:0]  td_ex_r  [TD_N+1];
  logic signed [DIFF_W-1:0]  td_ey_r  [TD_N+1];

  always_ff @(posedge clk) begin
    if (advance) begin
      td_rem_r[0]  <= (LEN_W+1)'(s3_dot);
      td_den_r[0]  <= LEN_W'(s3_lensq);
      td_q_r[0]    <= '0;
      td_mode_r[0] <= s3_mode;
      td_cx_r[0]   <= s2_cx_r;
      td_cy_r[0]   <= s2_cy_r;
      td_dx_r[0]   <= s2_dx_r;
      td_dy_r[0]   <= s2_dy_r;
      td_px_r[0]   <= s2_px_r;
      td_py_r[0]   <= s2_py_r;
      td_ex_r[0]   <= s2_ex_r;
      td_ey_r[0]   <= s2_ey_r;
    end
  end

  for (genvar k = 0; k < TD_N; k++) begin : g_tdiv
    logic [LEN_W:0] r2;
    logic           ge;
    assign r2 = {td_rem_r[k][LEN_W-1:0], 1'b0};
    assign ge = r2 >= (LEN_W+1)'(td_den_r[k]);
    always_ff @(posedge clk) begin
      if (advance) begin
        td_rem_r[k+1]  <= ge ? r2 - (LEN_W+1)'(td_den_r[k]) : r2;
        td_q_r[k+1]    <= {td_q_r[k][T_W-2:0], ge};
        td_den_r[k+1]  <= td_den_r[k];
        td_mode_r[k+1] <= td_mode_r[k];
        td_cx_r[k+1]   <= td_cx_r[k];
        td_cy_r[k+1]   <= td_cy_r[k];
        td_dx_r[k+1]   <= td_dx_r[k];
        td_dy_r[k+1]   <= td_dy_r[k];
        td_px_r[k+1]   <= td_px_r[k];
        td_py_r[k+1]   <= td_py_r[k];
        td_ex_r[k+1]   <= td_ex_r[k];
        td_ey_r[k+1]   <= td_ey_r[k];
      end
    end
  end

  // stage 4: offset along the wall, d * t
  logic signed [DIFF_W+T_W:0] s4_ox_r, s4_oy_r;
  mode_t                      s4_mode_r;
  logic signed [COORD_W-1:0]  s4_cx_r, s4_cy_r;
  logic signed [DIFF_W-1:0]   s4_px_r, s4_py_r, s4_ex_r, s4_ey_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_ox_r   <= (DIFF_W+T_W+1)'(td_dx_r[TD_N]) *
                   $signed({1'b0, td_q_r[TD_N]});
      s4_oy_r   <= (DIFF_W+T_W+1)'(td_dy_r[TD_N]) *
                   $signed({1'b0, td_q_r[TD_N]});
      s4_mode_r <= td_mode_r[TD_N];
      s4_cx_r   <= td_cx_r[TD_N];
      s4_cy_r   <= td_cy_r[TD_N];
      s4_px_r   <= td_px_r[TD_N];
      s4_py_r   <= td_py_r[TD_N];
      s4_ex_r   <= td_ex_r[TD_N];
      s4_ey_r   <= td_ey_r[TD_N];
    end
  end

  // stage 5: center minus closest point, rounded half up
  logic signed [DIFF_W+T_W+1:0] s5_rx, s5_ry;
  logic signed [Q_W-1:0]        s5_qx, s5_qy;

  always_comb begin
    s5_rx = ((DIFF_W+T_W+2)'(s4_ox_r) + (DIFF_W+T_W+2)'(1 << (T_W-1))) >>> T_W;
    s5_ry = ((DIFF_W+T_W+2)'(s4_oy_r) + (DIFF_W+T_W+2)'(1 << (T_W-1))) >>> T_W;
    case (s4_mode_r)
      MODE_A: begin
        s5_qx = Q_W'(s4_px_r);
        s5_qy = Q_W'(s4_py_r);
      end
      MODE_B: begin
        s5_qx = Q_W'(s4_ex_r);
        s5_qy = Q_W'(s4_ey_r);
      end
      default: begin
        s5_qx = Q_W'(s4_px_r) - Q_W'(s5_rx);
        s5_qy = Q_W'(s4_py_r) - Q_W'(s5_ry);
      end
    endcase
  end

  logic signed [Q_W-1:0]     s5_qx_r, s5_qy_r;
  logic signed [COORD_W-1:0] s5_cx_r, s5_cy_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_qx_r <= s5_qx;
      s5_qy_r <= s5_qy;
      s5_cx_r <= s4_cx_r;
      s5_cy_r <= s4_cy_r;
    end
  end

  // stage 6: squared components
  logic signed [2*Q_W-1:0]   s6_sx_r, s6_sy_r;
  logic signed [Q_W-1:0]     s6_qx_r, s6_qy_r;
  logic signed [COORD_W-1:0] s6_cx_r, s6_cy_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_sx_r <= s5_qx_r * s5_qx_r;
      s6_sy_r <= s5_qy_r * s5_qy_r;
      s6_qx_r <= s5_qx_r;
      s6_qy_r <= s5_qy_r;
      s6_cx_r <= s5_cx_r;
      s6_cy_r <= s5_cy_r;
    end
  end

  // stage 7: distance squared and the exact overlap test
  logic [2*Q_W:0] s7_d2;
  logic           s7_hit;

  assign s7_d2  = (2*Q_W+1)'($unsigned(s6_sx_r)) + (2*Q_W+1)'($unsigned(s6_sy_r));
  assign s7_hit = (s7_d2 != '0) && (s7_d2 < (2*Q_W+1)'(rsq_r));

  // square root, one root bit per stage; index 0 is stage 7
  logic [RAD2_W-1:0]         sq_rad_r [SQ_N+1];
  logic [ROOT_W+1:0]         sq_rem_r [SQ_N+1];
  logic [ROOT_W-1:0]         sq_root_r[SQ_N+1];
  logic                      sq_hit_r [SQ_N+1];
  logic                      sq_sx_r  [SQ_N+1];
  logic                      sq_sy_r  [SQ_N+1];
  logic [MAG_W-1:0]          sq_mx_r  [SQ_N+1];
  logic [MAG_W-1:0]          sq_my_r  [SQ_N+1];
  logic signed [COORD_W-1:0] sq_cx_r  [SQ_N+1];
  logic signed [COORD_W-1:0] sq_cy_r  [SQ_N+1];

  // component magnitudes stay below the radius when the test hits
  logic [Q_W-1:0] s7_ax, s7_ay;
  assign s7_ax = s6_qx_r[Q_W-1] ? Q_W'(-s6_qx_r) : Q_W'(s6_qx_r);
  assign s7_ay = s6_qy_r[Q_W-1] ? Q_W'(-s6_qy_r) : Q_W'(s6_qy_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_rad_r[0]  <= {s7_d2[2*RAD_W-1:0], (RAD2_W-2*RAD_W)'(0)};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_hit_r[0]  <= s7_hit;
      sq_sx_r[0]   <= s6_qx_r[Q_W-1];
      sq_sy_r[0]   <= s6_qy_r[Q_W-1];
      sq_mx_r[0]   <= s7_ax[MAG_W-1:0];
      sq_my_r[0]   <= s7_ay[MAG_W-1:0];
      sq_cx_r[0]   <= s6_cx_r;
      sq_cy_r[0]   <= s6_cy_r;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [ROOT_W+3:0] rr;
    logic [ROOT_W+3:0] trial;
    logic              ge;
    assign rr    = {sq_rem_r[k], sq_rad_r[k][RAD2_W-1 -: 2]};
    assign trial = (ROOT_W+4)'({sq_root_r[k], 2'b01});
    assign ge    = rr >= trial;
    always_ff @(posedge clk) begin
      if (advance) begin
        sq_rem_r[k+1]  <= ge ? (ROOT_W+2)'(rr - trial) : (ROOT_W+2)'(rr);
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
        sq_rad_r[k+1]  <= {sq_rad_r[k][RAD2_W-3:0], 2'b00};
        sq_hit_r[k+1]  <= sq_hit_r[k];
        sq_sx_r[k+1]   <= sq_sx_r[k];
        sq_sy_r[k+1]   <= sq_sy_r[k];
        sq_mx_r[k+1]   <= sq_mx_r[k];
        sq_my_r[k+1]   <= sq_my_r[k];
        sq_cx_r[k+1]   <= sq_cx_r[k];
        sq_cy_r[k+1]   <= sq_cy_r[k];
      end
    end
  end

  // stage 8: overlap, radius with 8 extra fraction bits minus distance
  logic [OV_W-1:0]           s8_ov_r;
  logic [ROOT_W-1:0]         s8_dd_r;
  logic                      s8_hit_r, s8_sx_r, s8_sy_r;
  logic [MAG_W-1:0]          s8_mx_r, s8_my_r;
  logic signed [COORD_W-1:0] s8_cx_r, s8_cy_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s8_ov_r  <= {radius_r, 8'd0} - OV_W'(sq_root_r[SQ_N]);
      s8_dd_r  <= sq_root_r[SQ_N];
      s8_hit_r <= sq_hit_r[SQ_N];
      s8_sx_r  <= sq_sx_r[SQ_N];
      s8_sy_r  <= sq_sy_r[SQ_N];
      s8_mx_r  <= sq_mx_r[SQ_N];
      s8_my_r  <= sq_my_r[SQ_N];
      s8_cx_r  <= sq_cx_r[SQ_N];
      s8_cy_r  <= sq_cy_r[SQ_N];
    end
  end

  // stage 9: magnitude times overlap
  logic [MAG_W+OV_W-1:0]     s9_px_r, s9_py_r;
  logic [ROOT_W-1:0]         s9_dd_r;
  logic                      s9_hit_r, s9_sx_r, s9_sy_r;
  logic signed [COORD_W-1:0] s9_cx_r, s9_cy_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s9_px_r  <= (MAG_W+OV_W)'(s8_mx_r) * (MAG_W+OV_W)'(s8_ov_r);
      s9_py_r  <= (MAG_W+OV_W)'(s8_my_r) * (MAG_W+OV_W)'(s8_ov_r);
      s9_dd_r  <= s8_dd_r;
      s9_hit_r <= s8_hit_r;
      s9_sx_r  <= s8_sx_r;
      s9_sy_r  <= s8_sy_r;
      s9_cx_r  <= s8_cx_r;
      s9_cy_r  <= s8_cy_r;
    end
  end

  // stage 10 feeds the move divider: (2*mag*ov + dd) / (2*dd)
  logic [NUM_W-1:0] s10_nx, s10_ny;
  assign s10_nx = {s9_px_r, 1'b0} + NUM_W'(s9_dd_r);
  assign s10_ny = {s9_py_r, 1'b0} + NUM_W'(s9_dd_r);

  // the quotient fits in MQ_W bits, so the top numerator bits seed the remainder
  logic [MREM_W-1:0]         md_rx_r [MD_N+1];
  logic [MREM_W-1:0]         md_ry_r [MD_N+1];
  logic [MQ_W-1:0]           md_nx_r [MD_N+1];
  logic [MQ_W-1:0]           md_ny_r [MD_N+1];
  logic [MQ_W-1:0]           md_qx_r [MD_N+1];
  logic [MQ_W-1:0]           md_qy_r [MD_N+1];
  logic [DEN_W-1:0]          md_den_r[MD_N+1];
  logic                      md_hit_r[MD_N+1];
  logic                      md_sx_r [MD_N+1];
  logic                      md_sy_r [MD_N+1];
  logic signed [COORD_W-1:0] md_cx_r [MD_N+1];
  logic signed [COORD_W-1:0] md_cy_r [MD_N+1];

  always_ff @(posedge clk) begin
    if (advance) begin
      md_rx_r[0]  <= MREM_W'(s10_nx[NUM_W-1:MQ_W]);
      md_ry_r[0]  <= MREM_W'(s10_ny[NUM_W-1:MQ_W]);
      md_nx_r[0]  <= s10_nx[MQ_W-1:0];
      md_ny_r[0]  <= s10_ny[MQ_W-1:0];
      md_qx_r[0]  <= '0;
      md_qy_r[0]  <= '0;
      md_den_r[0] <= {s9_dd_r, 1'b0};
      md_hit_r[0] <= s9_hit_r;
      md_sx_r[0]  <= s9_sx_r;
      md_sy_r[0]  <= s9_sy_r;
      md_cx_r[0]  <= s9_cx_r;
      md_cy_r[0]  <= s9_cy_r;
    end
  end

  for (genvar k = 0; k < MD_N; k++) begin : g_mdiv
    logic [MREM_W-1:0] rx, ry;
    logic              gx, gy;
    assign rx = {md_rx_r[k][MREM_W-2:0], md_nx_r[k][MQ_W-1]};
    assign ry = {md_ry_r[k][MREM_W-2:0], md_ny_r[k][MQ_W-1]};
    assign gx = rx >= MREM_W'(md_den_r[k]);
    assign gy = ry >= MREM_W'(md_den_r[k]);
    always_ff @(posedge clk) begin
      if (advance) begin
        md_rx_r[k+1]  <= gx ? rx - MREM_W'(md_den_r[k]) : rx;
        md_ry_r[k+1]  <= gy ? ry - MREM_W'(md_den_r[k]) : ry;
        md_nx_r[k+1]  <= {md_nx_r[k][MQ_W-2:0], 1'b0};
        md_ny_r[k+1]  <= {md_ny_r[k][MQ_W-2:0], 1'b0};
        md_qx_r[k+1]  <= {md_qx_r[k][MQ_W-2:0], gx};
        md_qy_r[k+1]  <= {md_qy_r[k][MQ_W-2:0], gy};
        md_den_r[k+1] <= md_den_r[k];
        md_hit_r[k+1] <= md_hit_r[k];
        md_sx_r[k+1]  <= md_sx_r[k];
        md_sy_r[k+1]  <= md_sy_r[k];
        md_cx_r[k+1]  <= md_cx_r[k];
        md_cy_r[k+1]  <= md_cy_r[k];
      end
    end
  end

  // output stage: apply signed move, saturate to the coordinate range
  localparam int SUM_W = MQ_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_W-1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [SUM_W-1:0] o_mx, o_my, o_sx, o_sy;
  logic signed [COORD_W-1:0] o_x_nxt, o_y_nxt;

  always_comb begin
    o_mx = md_sx_r[MD_N] ? -SUM_W'(md_qx_r[MD_N]) : SUM_W'(md_qx_r[MD_N]);
    o_my = md_sy_r[MD_N] ? -SUM_W'(md_qy_r[MD_N]) : SUM_W'(md_qy_r[MD_N]);
    o_sx = SUM_W'(md_cx_r[MD_N]) + (md_hit_r[MD_N] ? o_mx : '0);
    o_sy = SUM_W'(md_cy_r[MD_N]) + (md_hit_r[MD_N] ? o_my : '0);
    if (o_sx > SAT_HI) begin
      o_x_nxt = COORD_W'(SAT_HI);
    end else if (o_sx < SAT_LO) begin
      o_x_nxt = COORD_W'(SAT_LO);
    end else begin
      o_x_nxt = COORD_W'(o_sx);
    end
    if (o_sy > SAT_HI) begin
      o_y_nxt = COORD_W'(SAT_HI);
    end else if (o_sy < SAT_LO) begin
      o_y_nxt = COORD_W'(SAT_LO);
    end else begin
      o_y_nxt = COORD_W'(o_sy);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_new_x  <= o_x_nxt;
      out_new_y  <= o_y_nxt;
      out_pushed <= md_hit_r[MD_N];
    end
  end

  // ---------------------------------------------------------------
  // checks
  logic dd_in_range;
  assign dd_in_range = OV_W'(sq_root_r[SQ_N]) < {radius_r, 8'd0};

  `CSP_ASSERT_NXT(a_reset_empty, !rst_n, !out_valid, "out_valid after reset")
  `CSP_ASSERT_NXT(a_hold_on_stall, rst_n && !advance, $stable(vld_r) || !rst_n,
                  "pipeline moved while stalled")
  `CSP_ASSERT_IMP(a_root_below_radius, vld_r[3+TD_N+4+SQ_N-1] && sq_hit_r[SQ_N],
                  dd_in_range, "distance not below radius on overlap")

endmodule

/* tb/sv/testbench.sv */
// testbench for the circle segment pushout: directed table, then random walls
`timescale 1ns / 100ps

module testbench;
  import csp_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one resolved center as it should leave the block
  typedef struct {
    coord_t x;
    coord_t y;
    logic   pushed;
  } center_t;

  // one row of the directed table
  typedef struct {
    coord_t  cx, cy, ax, ay, bx, by;
    bit      typed;
    center_t want;
  } wall_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_center_x = '0, in_center_y = '0;
  coord_t in_wall_ax = '0, in_wall_ay = '0, in_wall_bx = '0, in_wall_by = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_new_x, out_new_y;
  logic out_pushed;
  logic cfg_we = 1'b0;
  logic [RAD_W-1:0] cfg_data = '0;

  center_t   awaited_centers[$];
  wall_row_t wall_table[$];
  logic [RAD_W-1:0] radius_now = RADIUS_RST;
  int errors = 0;
  bit stim_done = 1'b0;

  circle_segment_pushout dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_wall_ax(in_wall_ax), .in_wall_ay(in_wall_ay),
    .in_wall_bx(in_wall_bx), .in_wall_by(in_wall_by),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_new_x(out_new_x), .out_new_y(out_new_y), .out_pushed(out_pushed),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generous fixed limit, far above the slowest correct run
  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // gap length: mostly none or short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // floored integer square root, bit by bit
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // move along one axis: q * overlap / distance, rounded half away from zero
  function automatic longint axis_move(input longint q, input longint ov, input longint dd);
    longint mag, m;
    mag = (q < 0) ? -q : q;
    m = (2 * mag * ov + dd) / (2 * dd);
    return (q < 0) ? -m : m;
  endfunction

  function automatic coord_t clip_coord(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return coord_t'(v);
  endfunction

  // expected resolved center for one wall at the given radius
  function automatic center_t predict_pushout(input coord_t cx, cy, ax, ay, bx, by,
                                              input logic [RAD_W-1:0] rad);
    longint dx, dy, px, py, lensq, dot, qx, qy, t, rr, dd, ov;
    longint unsigned dist2;
    center_t res;
    dx = longint'(bx) - ax;
    dy = longint'(by) - ay;
    px = longint'(cx) - ax;
    py = longint'(cy) - ay;
    lensq = dx * dx + dy * dy;
    dot = px * dx + py * dy;
    rr = longint'(rad);
    if (lensq == 0 || dot <= 0) begin
      // before the first endpoint, or a wall of zero length
      qx = px;
      qy = py;
    end else if (dot >= lensq) begin
      qx = longint'(cx) - bx;
      qy = longint'(cy) - by;
    end else begin
      t = (dot << 16) / lensq;
      qx = px - ((dx * t + 32768) >>> 16);
      qy = py - ((dy * t + 32768) >>> 16);
    end
    dist2 = qx * qx + qy * qy;
    res.x = cx;
    res.y = cy;
    res.pushed = 1'b0;
    if (dist2 > 0 && dist2 < rr * rr) begin
      dd = floor_root(dist2 << 16);
      ov = (rr << 8) - dd;
      res.x = clip_coord(longint'(cx) + axis_move(qx, ov, dd));
      res.y = clip_coord(longint'(cy) + axis_move(qy, ov, dd));
      res.pushed = 1'b1;
    end
    return res;
  endfunction

  // drive one wall and hold it until the block takes the transaction
  task automatic send_wall(input coord_t cx, cy, ax, ay, bx, by,
                           input bit typed, input center_t want);
    center_t e;
    int n;
    e = typed ? want : predict_pushout(cx, cy, ax, ay, bx, by, radius_now);
    in_valid <= 1'b1;
    in_center_x <= cx;
    in_center_y <= cy;
    in_wall_ax <= ax;
    in_wall_ay <= ay;
    in_wall_bx <= bx;
    in_wall_by <= by;
    do @(posedge clk); while (in_stall);
    awaited_centers.push_back(e);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (awaited_centers.size() != 0) @(posedge clk);
  endtask

  // radius is written only with the pipe empty
  task automatic write_radius(input logic [RAD_W-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_now = v;
  endtask

  function automatic coord_t rnd_coord();
    return coord_t'($urandom_range(0, 65535));
  endfunction

  function automatic coord_t near_coord(input longint base, input int span);
    return clip_coord(base + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // random wall, mostly placed with the circle close to it
  task automatic send_random_wall();
    coord_t cx, cy, ax, ay, bx, by;
    longint kx, ky;
    int mode, k, span;
    center_t none;
    none = '{default: '0};
    span = int'(radius_now) + 40;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      cx = rnd_coord(); cy = rnd_coord(); ax = rnd_coord();
      ay = rnd_coord(); bx = rnd_coord(); by = rnd_coord();
    end else begin
      // first endpoint anywhere, the second one at or near it
      ax = rnd_coord();
      ay = rnd_coord();
      if (mode == 2) begin
        bx = ax;
        by = ay;
      end else begin
        bx = near_coord(ax, 3000);
        by = near_coord(ay, 3000);
      end
      // a point along the wall, a little past either end at times
      k = $urandom_range(0, 24);
      kx = longint'(ax) + (longint'(bx) - ax) * (k - 4) / 16;
      ky = longint'(ay) + (longint'(by) - ay) * (k - 4) / 16;
      cx = near_coord(kx, span);
      cy = near_coord(ky, span);
    end
    send_wall(cx, cy, ax, ay, bx, by, 1'b0, none);
  endtask

  task automatic add_row(input coord_t cx, cy, ax, ay, bx, by,
                         input bit typed, input coord_t ex, ey, input logic ep);
    wall_row_t r;
    r.cx = cx; r.cy = cy; r.ax = ax; r.ay = ay; r.bx = bx; r.by = by;
    r.typed = typed;
    r.want = '{ex, ey, ep};
    wall_table.push_back(r);
  endtask

  // random stalls on the result side, with stall-free stretches
  int stall_left = 0;
  bit stall_mode = 1'b0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = ($urandom_range(0, 2) == 0);
      stall_left = stall_mode ? gap_len() : $urandom_range(1, 60);
      out_stall <= stall_mode && stall_left > 0;
    end else begin
      stall_left--;
      out_stall <= stall_mode;
    end
  end

  // compare each result transaction with the oldest expected center
  always @(posedge clk) begin
    center_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_centers.size() == 0) begin
        report($sformatf("unexpected result x=%0d y=%0d pushed=%0b",
                         out_new_x, out_new_y, out_pushed));
      end else begin
        e = awaited_centers.pop_front();
        if (out_new_x !== e.x)
          report($sformatf("new_x %0d, expected %0d", out_new_x, e.x));
        if (out_new_y !== e.y)
          report($sformatf("new_y %0d, expected %0d", out_new_y, e.y));
        if (out_pushed !== e.pushed)
          report($sformatf("pushed %0b, expected %0b", out_pushed, e.pushed));
      end
    end
  end

  initial begin
    logic [RAD_W-1:0] radius_plan[5];
    radius_plan = '{12'd0, 12'd4095, 12'd1, 12'd0, 12'd240};
    radius_plan[3] = RAD_W'($urandom_range(2, 4094));

    // typed rows assume the reset radius of 15.0
    add_row(1000, 1000, -1000, -900, -900, -1000, 1, 1000, 1000, 0);  // far away
    add_row(500, 500, 500, 500, 500, 500, 1, 500, 500, 0);  // zero-length, on center
    add_row(0, 0, -100, 0, 100, 0, 1, 0, 0, 0);             // center on the wall
    add_row(0, 100, -1000, 0, 1000, 0, 1, 0, 240, 1);       // mid-wall push
    add_row(0, -100, -1000, 0, 1000, 0, 1, 0, -240, 1);
    add_row(-1100, 0, -1000, 0, 1000, 0, 1, -1240, 0, 1);   // before first endpoint
    add_row(1100, 0, -1000, 0, 1000, 0, 1, 1240, 0, 1);     // past second endpoint
    add_row(32767, 32767, -32768, -32768, -32768, -32768, 1, 32767, 32767, 0);
    add_row(-32768, -32768, 32767, 32767, 32767, -32768, 1, -32768, -32768, 0);
    add_row(32760, 0, 32750, -1000, 32750, 1000, 1, 32767, 0, 1);   // saturates high
    add_row(-32760, 0, -32750, 1000, -32750, -1000, 1, -32768, 0, 1); // saturates low
    add_row(-32768, 32767, -32768, -32768, 32767, 32767, 0, 0, 0, 0);
    add_row(32767, -32768, 32767, 32767, -32768, -32768, 0, 0, 0, 0);
    add_row(100, 50, 0, 0, 300, 200, 0, 0, 0, 0);           // diagonal wall
    add_row(-70, 90, 0, 0, -1, 1, 0, 0, 0, 0);              // very short wall
    add_row(203, 197, 200, 200, 200, 200, 0, 0, 0, 0);      // zero-length, touching
    add_row(300, 310, 0, 0, 300, 300, 0, 0, 0, 0);          // near second endpoint
    add_row(-5, -3, 0, 0, 600, -20, 0, 0, 0, 0);
    add_row(1, 0, 0, -32768, 0, 32767, 0, 0, 0, 0);         // long wall, one lsb off
    add_row(239, 0, 0, -500, 0, 500, 0, 0, 0, 0);           // just inside radius
    add_row(240, 0, 0, -500, 0, 500, 1, 240, 0, 0);         // exactly at radius

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (wall_table[i])
      send_wall(wall_table[i].cx, wall_table[i].cy, wall_table[i].ax, wall_table[i].ay,
                wall_table[i].bx, wall_table[i].by, wall_table[i].typed,
                wall_table[i].want);
    repeat (180) send_random_wall();

    // each phase starts from an empty pipe, which also makes the sender wait out all results
    foreach (radius_plan[p]) begin
      write_radius(radius_plan[p]);
      repeat (145) send_random_wall();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (awaited_centers.size() != 0)
      report($sformatf("%0d results never arrived", awaited_centers.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/csp_pkg.sv
design/circle_segment_pushout.sv
tb/sv/testbench.sv
